// ----- sv/thermal_token_bucket_grant_defines.svh -----
// Assertion macros for the thermal token bucket grant block.
// Used by the modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef THERMAL_TOKEN_BUCKET_GRANT_DEFINES_SVH
`define THERMAL_TOKEN_BUCKET_GRANT_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define TTBG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define TTBG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/ttbg_pkg.sv -----
// Shared types, constants and command codes of the thermal token bucket grant block.
// No dependencies; imported by ttbg_dp, ttbg_ctrl, the top level and the testbench.
`default_nettype none

package ttbg_pkg;

    localparam int TOKW = 24;
    localparam int PRODW = 52;
    localparam int DENW = 36;
    localparam int CFG_IDXW = 3;
    localparam int PROCESSES_DEF = 16;
    localparam logic [TOKW-1:0] TOK_MAX = 24'hFFFFFF;
    localparam logic [9:0] MS_PER_S = 10'd1000;
    // ceil(2^36 / 1000): exact floor division by 1000 for operands below 2^26
    localparam logic [26:0] RECIP_1000 = 27'd68719477;

    // Configuration register indexes
    localparam logic [CFG_IDXW-1:0] REG_MIN_TEMP = 3'd0;
    localparam logic [CFG_IDXW-1:0] REG_MAX_TEMP = 3'd1;
    localparam logic [CFG_IDXW-1:0] REG_INIT_TOK = 3'd2;
    localparam logic [CFG_IDXW-1:0] REG_MAX_TOK = 3'd3;
    localparam logic [CFG_IDXW-1:0] REG_BASE_RATE = 3'd4;
    localparam logic [CFG_IDXW-1:0] REG_RES_THR = 3'd5;

    // Configuration reset values
    localparam logic [6:0] MIN_TEMP_RST = 7'd50;
    localparam logic [6:0] MAX_TEMP_RST = 7'd79;
    localparam logic [TOKW-1:0] INIT_TOK_RST = 24'd0;
    localparam logic [TOKW-1:0] MAX_TOK_RST = 24'd25600;
    localparam logic [TOKW-1:0] BASE_RATE_RST = 24'd2560;
    localparam logic [15:0] RES_THR_RST = 16'd60;

    // Datapath operation codes
    localparam logic [3:0] OP_NONE = 4'd0;
    localparam logic [3:0] OP_LOAD = 4'd1;
    localparam logic [3:0] OP_RATE = 4'd2;
    localparam logic [3:0] OP_DIV_GO = 4'd3;
    localparam logic [3:0] OP_RATE_SET = 4'd4;
    localparam logic [3:0] OP_MUL_MS = 4'd5;
    localparam logic [3:0] OP_FILL = 4'd6;
    localparam logic [3:0] OP_RD = 4'd7;
    localparam logic [3:0] OP_EVAL = 4'd8;
    localparam logic [3:0] OP_GRANT = 4'd9;
    localparam logic [3:0] OP_SHARE_MUL = 4'd10;
    localparam logic [3:0] OP_SHARE_UPD = 4'd11;
    localparam logic [3:0] OP_RESULT = 4'd12;
    localparam logic [3:0] OP_REM = 4'd13;
    localparam logic [3:0] OP_MS_REM = 4'd14;
    localparam logic [3:0] OP_MS_DIV = 4'd15;

    typedef struct packed {
        logic            action;
        logic [6:0]      temperature;
        logic [15:0]     elapsed_ms;
        logic [3:0]      process_id;
        logic [TOKW-1:0] requested_tokens;
        logic [15:0]     wait_seconds;
        logic [7:0]      pending_count;
    } item_t;

    typedef struct packed {
        logic            granted;
        logic [TOKW-1:0] reserved_added;
        logic [TOKW-1:0] available_now;
        logic [TOKW-1:0] rate_now;
    } result_t;

    typedef struct packed {
        logic [3:0] op;
    } ttbg_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic pid_ok;
        logic band;
        logic grant;
        logic share;
        logic div_busy;
    } ttbg_sts_t;

endpackage

`default_nettype wire

// ----- sv/ttbg_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ttbg_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/ttbg_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
`default_nettype none

module ttbg_div #(
    parameter int NUMW = 52,
    parameter int DENW = 36
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [NUMW-1:0] num,
    input  wire logic [DENW-1:0] den,
    output logic      [NUMW-1:0] quo,
    output logic                 busy
);

    localparam int CNTW = $clog2(NUMW + 1);

    logic [NUMW-1:0] quo_reg, quo_next;
    logic [DENW-1:0] rem_reg, rem_next;
    logic [DENW-1:0] den_reg;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic [DENW:0]   rem_sh;
    logic [DENW:0]   diff;

    // One shift-subtract step
    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[NUMW-1]};
        diff = rem_sh - {1'b0, den_reg};
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quo_next = num;
            rem_next = '0;
            cnt_next = CNTW'(NUMW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[DENW])
            begin
                rem_next = diff[DENW-1:0];
            end
            else
            begin
                rem_next = rem_sh[DENW-1:0];
            end
            quo_next = {quo_reg[NUMW-2:0], ~diff[DENW]};
            cnt_next = cnt_reg - 1'b1;
            busy_next = (cnt_reg != CNTW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign quo = quo_reg;
    assign busy = busy_reg;

endmodule

`default_nettype wire

// ----- sv/ttbg_dp.sv -----
// Datapath: configuration registers, bucket state, reserve RAM, multipliers, divider.
// Depends on ttbg_pkg, ttbg_ram and ttbg_div.
`default_nettype none

module ttbg_dp
    import ttbg_pkg::*;
#(
    parameter int PROCESSES = PROCESSES_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ttbg_cmd_t           cmd,
    output ttbg_sts_t                sts,
    input  wire item_t               item,
    input  wire logic                cfg_valid,
    input  wire logic [CFG_IDXW-1:0] cfg_index,
    input  wire logic [TOKW-1:0]     cfg_data,
    output result_t                  result
);

    localparam int AW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int TOTW = TOKW + AW;
    localparam logic [8:0] PROC_LIM = 9'(PROCESSES);

    // Configuration
    logic [6:0]      min_temp_reg, max_temp_reg;
    logic [TOKW-1:0] max_tok_reg, base_rate_reg;
    logic [15:0]     res_thr_reg;

    // State
    item_t           item_reg;
    logic [TOKW-1:0] avail_reg, avail_next;
    logic [TOKW-1:0] rate_reg, rate_next;
    logic [TOTW-1:0] total_reg, total_next;
    logic [PROCESSES-1:0] vld_reg, vld_next;
    logic            vld_q_reg;
    logic [TOKW-1:0] res_reg;
    logic [PRODW-1:0] prod_reg, prod_next;
    logic [DENW-1:0] den_reg, den_next;
    logic            granted_reg, granted_next;
    logic [TOKW-1:0] added_reg, added_next;
    result_t         result_reg;

    // Refill pipeline: rate split into thousands and remainder
    logic [14:0]     rq_reg, rq_next;
    logic [9:0]      rr_reg, rr_next;
    logic [30:0]     hi_reg, hi_next;
    logic [25:0]     lo_reg, lo_next;
    logic [16:0]     lq_reg, lq_next;

    // RAM and divider wiring
    logic            ram_we;
    logic [TOKW-1:0] ram_wdata;
    logic [TOKW-1:0] ram_rdata;
    logic [PRODW-1:0] quo;
    logic            div_busy;

    // Decode of the latched item
    logic [8:0]      pid_ext;
    logic [AW-1:0]   addr;
    logic [6:0]      t;
    logic [TOKW:0]   have;
    logic [TOKW:0]   left;
    logic [7:0]      n_eff;
    logic [27:0]     m9a;
    logic [27:0]     m10;
    logic [51:0]     share_prod;
    logic [35:0]     share_den;
    logic [30:0]     rate_prod;
    logic [50:0]     rq_prod;
    logic [24:0]     rr_full;
    logic [30:0]     hi_prod;
    logic [25:0]     lo_prod;
    logic [52:0]     lq_prod;
    logic [TOTW:0]   used;
    logic [TOKW-1:0] cap;
    logic [PRODW:0]  fill_sum;
    logic [TOKW-1:0] room;
    logic [TOKW-1:0] amt;

    assign pid_ext = {5'd0, item_reg.process_id};
    assign addr = pid_ext[AW-1:0];
    assign t = item_reg.temperature;

    // Status to the controller
    always_comb
    begin
        have = {1'b0, avail_reg} + {1'b0, res_reg};
        sts.is_tick = !item_reg.action;
        sts.pid_ok = pid_ext < PROC_LIM;
        sts.band = (t >= min_temp_reg) && (t < max_temp_reg);
        sts.grant = have >= {1'b0, item_reg.requested_tokens};
        sts.share = item_reg.wait_seconds > res_thr_reg;
        sts.div_busy = div_busy;
    end

    // Arithmetic for each operation
    always_comb
    begin
        left = have - {1'b0, item_reg.requested_tokens};
        n_eff = (item_reg.pending_count == 8'd0) ? 8'd1 : item_reg.pending_count;
        m9a = 28'(max_tok_reg) + (28'(avail_reg) << 3) + 28'(avail_reg);
        m10 = (28'(max_tok_reg) << 3) + (28'(max_tok_reg) << 1);
        share_prod = 52'(avail_reg) * 52'(m9a);
        share_den = 36'(m10) * 36'(n_eff);
        rate_prod = 31'(base_rate_reg) * 31'(max_temp_reg - t);
        // ms * rate / 1000 = ms * (rate / 1000) + ms * (rate % 1000) / 1000
        rq_prod = 51'(rate_reg) * 51'(RECIP_1000);
        rr_full = 25'(rate_reg) - 25'(rq_reg) * 25'(MS_PER_S);
        hi_prod = 31'(item_reg.elapsed_ms) * 31'(rq_reg);
        lo_prod = 26'(item_reg.elapsed_ms) * 26'(rr_reg);
        lq_prod = 53'(lo_reg) * 53'(RECIP_1000);
        used = (TOTW+1)'(avail_reg) + (TOTW+1)'(total_reg);
        cap = TOKW'(TOTW'(max_tok_reg) - total_reg);
        fill_sum = (PRODW+1)'(avail_reg) + (PRODW+1)'(hi_reg) + (PRODW+1)'(lq_reg);
        room = TOK_MAX - res_reg;
        amt = (quo < PRODW'(avail_reg)) ? quo[TOKW-1:0] : avail_reg;
        if (amt > room)
        begin
            amt = room;
        end
    end

    // Next-state selection
    always_comb
    begin
        avail_next = avail_reg;
        rate_next = rate_reg;
        total_next = total_reg;
        vld_next = vld_reg;
        prod_next = prod_reg;
        den_next = den_reg;
        granted_next = granted_reg;
        added_next = added_reg;
        rq_next = rq_reg;
        rr_next = rr_reg;
        hi_next = hi_reg;
        lo_next = lo_reg;
        lq_next = lq_reg;
        ram_we = 1'b0;
        ram_wdata = '0;
        case (cmd.op)
            OP_LOAD:
            begin
                granted_next = 1'b0;
                added_next = '0;
            end
            OP_RATE:
            begin
                if (t < min_temp_reg)
                begin
                    rate_next = base_rate_reg;
                end
                else
                begin
                    rate_next = '0;
                end
                prod_next = PRODW'(rate_prod);
                den_next = DENW'(max_temp_reg - min_temp_reg);
            end
            OP_RATE_SET:
            begin
                rate_next = quo[TOKW-1:0];
            end
            OP_MUL_MS:
            begin
                rq_next = rq_prod[50:36];
            end
            OP_REM:
            begin
                rr_next = rr_full[9:0];
                hi_next = hi_prod;
            end
            OP_MS_REM:
            begin
                lo_next = lo_prod;
            end
            OP_MS_DIV:
            begin
                lq_next = lq_prod[52:36];
            end
            OP_FILL:
            begin
                // Refill only while capacity minus reserves exceeds the count
                if (used < (TOTW+1)'(max_tok_reg))
                begin
                    if (fill_sum > (PRODW+1)'(cap))
                    begin
                        avail_next = cap;
                    end
                    else
                    begin
                        avail_next = fill_sum[TOKW-1:0];
                    end
                end
            end
            OP_GRANT:
            begin
                avail_next = left[TOKW] ? TOK_MAX : left[TOKW-1:0];
                total_next = total_reg - TOTW'(res_reg);
                ram_we = 1'b1;
                ram_wdata = '0;
                vld_next[addr] = 1'b1;
                granted_next = 1'b1;
            end
            OP_SHARE_MUL:
            begin
                if (max_tok_reg == '0)
                begin
                    prod_next = PRODW'(avail_reg);
                    den_next = DENW'(n_eff);
                end
                else
                begin
                    prod_next = share_prod;
                    den_next = share_den;
                end
            end
            OP_SHARE_UPD:
            begin
                avail_next = avail_reg - amt;
                total_next = total_reg + TOTW'(amt);
                ram_we = 1'b1;
                ram_wdata = res_reg + amt;
                vld_next[addr] = 1'b1;
                added_next = amt;
            end
            default:
            begin
            end
        endcase
        // Writing initial tokens reloads the bucket
        if (cfg_valid && (cfg_index == REG_INIT_TOK))
        begin
            avail_next = cfg_data;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_temp_reg <= MIN_TEMP_RST;
            max_temp_reg <= MAX_TEMP_RST;
            max_tok_reg <= MAX_TOK_RST;
            base_rate_reg <= BASE_RATE_RST;
            res_thr_reg <= RES_THR_RST;
            avail_reg <= '0;
            rate_reg <= '0;
            total_reg <= '0;
            vld_reg <= '0;
        end
        else
        begin
            avail_reg <= avail_next;
            rate_reg <= rate_next;
            total_reg <= total_next;
            vld_reg <= vld_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_MIN_TEMP:  min_temp_reg <= cfg_data[6:0];
                    REG_MAX_TEMP:  max_temp_reg <= cfg_data[6:0];
                    REG_MAX_TOK:   max_tok_reg <= cfg_data;
                    REG_BASE_RATE: base_rate_reg <= cfg_data;
                    REG_RES_THR:   res_thr_reg <= cfg_data[15:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        den_reg <= den_next;
        granted_reg <= granted_next;
        added_reg <= added_next;
        rq_reg <= rq_next;
        rr_reg <= rr_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        lq_reg <= lq_next;
        if (cmd.op == OP_LOAD)
        begin
            item_reg <= item;
        end
        if (cmd.op == OP_RD)
        begin
            vld_q_reg <= vld_reg[addr];
        end
        if (cmd.op == OP_EVAL)
        begin
            res_reg <= vld_q_reg ? ram_rdata : '0;
        end
        if (cmd.op == OP_RESULT)
        begin
            result_reg <= '{granted: granted_reg, reserved_added: added_reg,
                            available_now: avail_reg, rate_now: rate_reg};
        end
    end

    ttbg_ram #(
        .WIDTH (TOKW),
        .DEPTH (PROCESSES)
    ) u_res_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (addr),
        .wr_data (ram_wdata),
        .rd_en   (cmd.op == OP_RD),
        .rd_addr (addr),
        .rd_data (ram_rdata)
    );

    ttbg_div #(
        .NUMW (PRODW),
        .DENW (DENW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.op == OP_DIV_GO),
        .num   (prod_reg),
        .den   (den_reg),
        .quo   (quo),
        .busy  (div_busy)
    );

    assign result = result_reg;

endmodule

`default_nettype wire

// ----- sv/ttbg_ctrl.sv -----
// Controller state machine: sequences datapath operations and owns the handshakes.
// Depends on ttbg_pkg and the assertion macro header.
`default_nettype none

`include "thermal_token_bucket_grant_defines.svh"

module ttbg_ctrl
    import ttbg_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    output logic           item_ready,
    output logic           result_valid,
    input  wire logic      result_ready,
    input  wire ttbg_sts_t sts,
    output ttbg_cmd_t      cmd
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DISP  = 5'd1;
    localparam logic [4:0] S_RATE  = 5'd2;
    localparam logic [4:0] S_RDIV  = 5'd3;
    localparam logic [4:0] S_RWAIT = 5'd4;
    localparam logic [4:0] S_RSET  = 5'd5;
    localparam logic [4:0] S_MMS   = 5'd6;
    localparam logic [4:0] S_REM   = 5'd7;
    localparam logic [4:0] S_MSR   = 5'd8;
    localparam logic [4:0] S_FILL  = 5'd9;
    localparam logic [4:0] S_RD    = 5'd10;
    localparam logic [4:0] S_EVAL  = 5'd11;
    localparam logic [4:0] S_DEC   = 5'd12;
    localparam logic [4:0] S_SMUL  = 5'd13;
    localparam logic [4:0] S_SDIV  = 5'd14;
    localparam logic [4:0] S_SWAIT = 5'd15;
    localparam logic [4:0] S_SUPD  = 5'd16;
    localparam logic [4:0] S_DONE  = 5'd17;
    localparam logic [4:0] S_MSD   = 5'd18;

    logic [4:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    assign item_ready = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;

    // Sequencing
    always_comb
    begin
        state_next = state_reg;
        cmd.op = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.op = OP_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (sts.is_tick)
                begin
                    state_next = S_RATE;
                end
                else if (sts.pid_ok)
                begin
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RATE:
            begin
                cmd.op = OP_RATE;
                state_next = sts.band ? S_RDIV : S_MMS;
            end
            S_RDIV:
            begin
                cmd.op = OP_DIV_GO;
                state_next = S_RWAIT;
            end
            S_RWAIT:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_RSET;
                end
            end
            S_RSET:
            begin
                cmd.op = OP_RATE_SET;
                state_next = S_MMS;
            end
            // Refill amount: four reciprocal-multiply steps
            S_MMS:
            begin
                cmd.op = OP_MUL_MS;
                state_next = S_REM;
            end
            S_REM:
            begin
                cmd.op = OP_REM;
                state_next = S_MSR;
            end
            S_MSR:
            begin
                cmd.op = OP_MS_REM;
                state_next = S_MSD;
            end
            S_MSD:
            begin
                cmd.op = OP_MS_DIV;
                state_next = S_FILL;
            end
            S_FILL:
            begin
                cmd.op = OP_FILL;
                state_next = S_DONE;
            end
            S_RD:
            begin
                cmd.op = OP_RD;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.op = OP_EVAL;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (sts.grant)
                begin
                    cmd.op = OP_GRANT;
                    state_next = S_DONE;
                end
                else if (sts.share)
                begin
                    state_next = S_SMUL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SMUL:
            begin
                cmd.op = OP_SHARE_MUL;
                state_next = S_SDIV;
            end
            S_SDIV:
            begin
                cmd.op = OP_DIV_GO;
                state_next = S_SWAIT;
            end
            S_SWAIT:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_SUPD;
                end
            end
            S_SUPD:
            begin
                cmd.op = OP_SHARE_UPD;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Wait for the output register to free up
                if (!out_valid_reg || result_ready)
                begin
                    cmd.op = OP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.op == OP_RESULT)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `TTBG_ASSERT_NEXT(a_accept_dispatch, item_valid && item_ready, state_reg == S_DISP, "accepted request not dispatched")
    `TTBG_ASSERT_NEXT(a_done_presents, (state_reg == S_DONE) && (!out_valid_reg || result_ready), out_valid_reg && (state_reg == S_IDLE), "finished request not presented")
    `TTBG_ASSERT_IMP(a_div_free, cmd.op == OP_DIV_GO, !sts.div_busy, "divider started while busy")

endmodule

`default_nettype wire

// ----- sv/thermal_token_bucket_grant.sv -----
// Top level of the thermal token bucket grant block.
// Depends on ttbg_pkg, ttbg_ctrl and ttbg_dp.
//
// Usage:
//   item channel (item_valid/item_ready/item) takes one request: a tick
//   (action 0) that derates the refill rate by temperature and refills the
//   bucket, or a token request (action 1) for one process.
//   result channel (result_valid/result_ready/result) returns exactly one
//   result per request, in order.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes registers
//   0..5; it is always ready; the user must use it only while the block is idle;
//   the block itself does not enforce this.
// The shared divider gives one quotient bit a cycle; the refill amount is
// found by reciprocal multiply. Ticks outside the derating band and requests
// granted or refused without reserve skip the divider; the others use it.
// One request is worked on at a time; a new one is taken as soon as the
// previous result sits in the output register, even if it is not yet taken.
// A stalled receiver holds the finished result in the controller until the
// output register frees. Reset clears bucket, rate and all reserves at once.
`default_nettype none

module thermal_token_bucket_grant
    import ttbg_pkg::*;
#(
    parameter int PROCESSES = PROCESSES_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_ready,
    input  wire item_t               item,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output result_t                  result,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CFG_IDXW-1:0] cfg_index,
    input  wire logic [TOKW-1:0]     cfg_data
);

    ttbg_cmd_t cmd;
    ttbg_sts_t sts;

    assign cfg_ready = 1'b1;

    ttbg_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    ttbg_dp #(
        .PROCESSES (PROCESSES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for the thermal token bucket grant block.
// Depends on ttbg_pkg and thermal_token_bucket_grant; predicts each result in a scoreboard class.
`default_nettype none

module testbench;
    import ttbg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPROC = 16;
    localparam int ITEM_W = $bits(item_t);
    localparam longint CYCLE_LIMIT = 2000000;

    // Bucket predictor and store of expected results
    class bucket_scoreboard;
        logic [6:0]      min_t, max_t;
        logic [TOKW-1:0] max_tok, base_rate;
        logic [15:0]     res_thr;
        logic [TOKW-1:0] avail, rate;
        logic [TOKW-1:0] reserve[NPROC];
        longint unsigned reserve_sum;
        result_t         pending_results[$];
        int              errors;

        function void clear();
            min_t = MIN_TEMP_RST; max_t = MAX_TEMP_RST; max_tok = MAX_TOK_RST;
            base_rate = BASE_RATE_RST; res_thr = RES_THR_RST;
            avail = '0; rate = '0; reserve_sum = 0; errors = 0;
            foreach (reserve[i]) reserve[i] = '0;
        endfunction

        function void write_reg(logic [CFG_IDXW-1:0] idx, logic [TOKW-1:0] d);
            case (idx)
                REG_MIN_TEMP:  min_t = d[6:0];
                REG_MAX_TEMP:  max_t = d[6:0];
                REG_INIT_TOK:  avail = d;
                REG_MAX_TOK:   max_tok = d;
                REG_BASE_RATE: base_rate = d;
                REG_RES_THR:   res_thr = d[15:0];
                default: ;
            endcase
        endfunction

        // Note one accepted request and queue its expected result
        function void note_request(item_t it);
            result_t r;
            longint unsigned add, have, a, n, amt, room;
            longint cap;
            r = '0;
            if (it.action == 1'b0) begin
                if (it.temperature < min_t) rate = base_rate;
                else if (it.temperature >= max_t) rate = '0;
                else rate = (longint'(base_rate) * (max_t - it.temperature))
                            / (max_t - min_t);
                add = (longint'(it.elapsed_ms) * rate) / 1000;
                cap = longint'(max_tok) - longint'(reserve_sum);
                if (cap > longint'(avail)) begin
                    have = avail + add;
                    if (have > cap) have = cap;
                    avail = have[TOKW-1:0];
                end
            end else begin
                have = longint'(avail) + reserve[it.process_id];
                if (have >= it.requested_tokens) begin
                    have = have - it.requested_tokens;
                    avail = (have > TOK_MAX) ? TOK_MAX : have[TOKW-1:0];
                    reserve_sum -= reserve[it.process_id];
                    reserve[it.process_id] = '0;
                    r.granted = 1'b1;
                end else if (it.wait_seconds > res_thr) begin
                    a = avail;
                    n = (it.pending_count == 0) ? 1 : it.pending_count;
                    if (max_tok == 0) amt = a / n;
                    else amt = (a * (longint'(max_tok) + 9 * a)) / (10 * longint'(max_tok) * n);
                    if (amt > a) amt = a;
                    room = TOK_MAX - reserve[it.process_id];
                    if (amt > room) amt = room;
                    r.reserved_added = amt[TOKW-1:0];
                    reserve[it.process_id] += amt[TOKW-1:0];
                    reserve_sum += amt;
                    avail -= amt[TOKW-1:0];
                end
            end
            r.available_now = avail;
            r.rate_now = rate;
            pending_results = {pending_results, r};
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(result_t got);
            result_t e;
            if (pending_results.size() == 0) begin
                $error("unexpected result %h", got);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (got.granted !== e.granted) begin
                $error("granted: expected %0d actual %0d", e.granted, got.granted);
                errors++;
            end
            if (got.reserved_added !== e.reserved_added) begin
                $error("reserved_added: expected %0d actual %0d",
                       e.reserved_added, got.reserved_added);
                errors++;
            end
            if (got.available_now !== e.available_now) begin
                $error("available_now: expected %0d actual %0d",
                       e.available_now, got.available_now);
                errors++;
            end
            if (got.rate_now !== e.rate_now) begin
                $error("rate_now: expected %0d actual %0d", e.rate_now, got.rate_now);
                errors++;
            end
        endfunction
    endclass

    logic clk, rst_n;
    logic item_valid, item_ready, result_valid, result_ready, cfg_valid, cfg_ready;
    item_t item;
    result_t result;
    logic [CFG_IDXW-1:0] cfg_index;
    logic [TOKW-1:0] cfg_data;

    bucket_scoreboard sb;
    int send_idle_pct, recv_stall_pct;
    bit hold_off;
    longint cycles;

    thermal_token_bucket_grant u_dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
            result_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checking
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_result(result);
    end

    // Valid stays up after acceptance; the next call drops it or replaces the payload
    task automatic send_request(item_t it);
        cfg_valid <= 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        sb.note_request(it);
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (130) @(posedge clk);
    endtask

    // Valid stays up after the write; the next request drops it
    task automatic write_reg(logic [CFG_IDXW-1:0] idx, logic [TOKW-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, d);
    endtask

    function automatic item_t make_tick(int t, int ms);
        item_t it;
        it = item_t'(ITEM_W'({$urandom, $urandom, $urandom}));
        it.action = 1'b0;
        it.temperature = t[6:0];
        it.elapsed_ms = ms[15:0];
        return it;
    endfunction

    function automatic item_t make_ask(int pid, logic [TOKW-1:0] req, int w, int pc);
        item_t it;
        it = item_t'(ITEM_W'({$urandom, $urandom, $urandom}));
        it.action = 1'b1;
        it.process_id = pid[3:0];
        it.requested_tokens = req;
        it.wait_seconds = w[15:0];
        it.pending_count = pc[7:0];
        return it;
    endfunction

    // Random request, scaled to the bucket size most of the time
    function automatic item_t random_request();
        logic [TOKW-1:0] req;
        int sel;
        sel = $urandom_range(99);
        if ($urandom_range(99) < 45)
            return make_tick($urandom_range(127),
                             ($urandom_range(9) == 0) ? $urandom_range(65535)
                                                      : $urandom_range(5000));
        if (sel < 70) req = TOKW'($urandom_range(sb.max_tok / 4 + 1));
        else if (sel < 85) req = TOKW'($urandom_range(24'hFFFFFF));
        else req = TOKW'(sb.avail + $urandom_range(3) - 1);
        return make_ask($urandom_range(15), req,
                        ($urandom_range(3) == 0) ? $urandom_range(65535)
                                                 : $urandom_range(sb.res_thr + 40),
                        ($urandom_range(7) == 0) ? $urandom_range(255)
                                                 : $urandom_range(1, 8));
    endfunction

    task automatic random_settings();
        int lo;
        lo = $urandom_range(127);
        write_reg(REG_MIN_TEMP, TOKW'(lo));
        write_reg(REG_MAX_TEMP, TOKW'(($urandom_range(5) == 0) ? $urandom_range(127)
                                                               : $urandom_range(lo, 127)));
        write_reg(REG_MAX_TOK, TOKW'(($urandom_range(5) == 0) ? $urandom_range(24'hFFFFFF)
                                                              : $urandom_range(1000, 200000)));
        write_reg(REG_BASE_RATE, TOKW'(($urandom_range(5) == 0) ? $urandom_range(24'hFFFFFF)
                                                                : $urandom_range(100000)));
        write_reg(REG_RES_THR, TOKW'(($urandom_range(5) == 0) ? $urandom_range(65535)
                                                              : $urandom_range(200)));
        write_reg(REG_INIT_TOK, TOKW'($urandom_range(sb.max_tok)));
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        rst_n = 1'b0;
        cycles = 0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        item_valid = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_MIN_TEMP;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset defaults, band edges, grants, reserves, highest pid
        send_request(make_tick(0, 65535));
        send_request(make_tick(49, 1000));
        send_request(make_tick(50, 1000));
        send_request(make_tick(65, 30000));
        send_request(make_tick(79, 1000));
        send_request(make_tick(127, 0));
        send_request(make_ask(3, 24'd0, 0, 1));
        send_request(make_ask(3, 24'hFFFFFF, 61, 1));
        send_request(make_ask(3, 24'hFFFFFF, 65535, 0));
        send_request(make_ask(4, 24'hFFFFFF, 60, 255));
        send_request(make_ask(3, 24'd1, 0, 1));
        send_request(make_ask(15, 24'd256, 100, 2));
        wait_drained();
        write_reg(REG_MAX_TOK, 24'd0);
        write_reg(REG_INIT_TOK, 24'hFFFFFF);
        write_reg(REG_RES_THR, 24'd0);
        send_request(make_tick(0, 65535));
        send_request(make_ask(7, 24'hFFFFFF, 1, 3));
        send_request(make_ask(7, 24'hFFFFFF, 1, 1));
        send_request(make_ask(7, 24'd5, 0, 1));
        wait_drained();
        write_reg(REG_MIN_TEMP, 24'd100);
        write_reg(REG_MAX_TEMP, 24'd20);
        write_reg(REG_MAX_TOK, 24'hFFFFFF);
        write_reg(REG_BASE_RATE, 24'hFFFFFF);
        write_reg(REG_RES_THR, 24'hFFFF);
        send_request(make_tick(99, 65535));
        send_request(make_tick(100, 100));
        send_request(make_tick(0, 1));
        send_request(make_ask(0, 24'hFFFFFF, 65535, 1));
        wait_drained();

        // Random phases across idle mixes and settings
        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            if (ph != 0) random_settings();
            if (ph == 2) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (600) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int i = 0; i < 110; i++) begin
                send_request(random_request());
                if (i == 55) wait_drained();
            end
            wait_drained();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+sv
sv/ttbg_pkg.sv
sv/ttbg_ram.sv
sv/ttbg_div.sv
sv/ttbg_dp.sv
sv/ttbg_ctrl.sv
sv/thermal_token_bucket_grant.sv
test/testbench.sv
